// File: hw/rtl/rom_ram_bank_switch_mapper_assert.svh
// Assertion macros used by the mapper's top-level RTL.
`ifndef ROM_RAM_BANK_SWITCH_MAPPER_ASSERT_SVH
`define ROM_RAM_BANK_SWITCH_MAPPER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRBSM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mapper assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RRBSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mapper assertion failed");

`endif

// File: hw/rtl/rrbsm_pkg.sv
// Types, constants and helper functions of the bank-switch mapper.
package rrbsm_pkg;

   localparam int RAM_BANKS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int RAM_BANK_BYTES  = 8192;
   localparam int ROM_BANK_BYTES  = 16384;
   localparam int RAM_IDX_W       = 17;
   localparam int ROM_BANK_W      = 9;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   localparam int   CSR_IDX_W     = 1;
   localparam int   CSR_DATA_W    = 5;
   localparam logic CSR_ROM_LOG2  = 1'b0;
   localparam logic CSR_RAM_COUNT = 1'b1;

   localparam logic [1:0] OP_PASS   = 2'd0;
   localparam logic [1:0] OP_RAM_RD = 2'd1;
   localparam logic [1:0] OP_RAM_WR = 2'd2;

   localparam logic [3:0] RAM_EN_KEY    = 4'hA;
   localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;
   localparam logic [3:0] LOG2_RESET    = 4'd1;
   localparam logic [8:0] ROM_BANK_RESET = 9'd1;

   typedef struct packed {
      logic        func;
      logic [15:0] bus_addr;
      logic [7:0]  write_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_byte;
      logic        rom_fetch;
      logic [22:0] rom_addr;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  ram_bank;
      logic [12:0] ram_offset;
      logic [7:0]  wr_byte;
      rsp_type     rsp;
   } cmd_type;

   typedef struct packed {
      logic clr_busy;
   } back_status_type;

   function automatic logic [ROM_BANK_W-1:0] rom_mask(input logic [3:0] lg);
      logic [ROM_BANK_W-1:0] m;
      for (int i = 0; i < ROM_BANK_W; i++) begin
         m[i] = (lg > 4'(i));
      end
      return m;
   endfunction

endpackage

// File: hw/rtl/rom_ram_bank_switch_mapper.sv
// Top level of the cartridge ROM/RAM bank-switch mapper.
//
//   channel   ports                             transfer when
//   request   req_push, req_full, req_data      req_push and not req_full
//   response  rsp_empty, rsp_pop, rsp_data      rsp_pop and not rsp_empty
//   control   csr_we, csr_idx, csr_wdata        csr_we
//
// One access is taken every cycle while req_full is low; its result passes the front decode,
// the command queue, the back end's registered RAM read port, then the result queue.
// After reset the back end clears the RAM one byte a cycle, RAM_BANKS * 8192 bytes
// (131072 with the default), and req_full stays high meanwhile; control writes are taken.
// A stalled response side fills the result queue, then the command queue, then raises
// req_full.
module rom_ram_bank_switch_mapper
   import rrbsm_pkg::*;
#(
   parameter int RAM_BANKS   = RAM_BANKS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "rom_ram_bank_switch_mapper_assert.svh"

   localparam int CNT_W = $clog2(QUEUE_DEPTH) + 1;

   logic            accept;
   cmd_type         front_cmd, back_cmd;
   logic            cmd_full, cmd_empty, cmd_pop;
   logic            res_push, res_full;
   rsp_type         res_data;
   logic [CNT_W-1:0] res_count;
   back_status_type back_status;

   assign req_full = cmd_full || back_status.clr_busy;
   assign accept   = req_push && !req_full;

   rrbsm_front #(
      .RAM_BANKS (RAM_BANKS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .cmd       (front_cmd)
   );

   rrbsm_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_cmd),
      .pop       (cmd_pop),
      .pop_data  (back_cmd),
      .full      (cmd_full),
      .empty     (cmd_empty),
      .count     ()
   );

   rrbsm_back #(
      .RAM_BANKS   (RAM_BANKS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .res_count (res_count),
      .res_push  (res_push),
      .res_data  (res_data),
      .status    (back_status)
   );

   rrbsm_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .pop       (rsp_pop && !rsp_empty),
      .pop_data  (rsp_data),
      .full      (res_full),
      .empty     (rsp_empty),
      .count     (res_count)
   );

   `RRBSM_ASSERT_SAME(a_full_while_clearing, clock, reset, back_status.clr_busy, req_full)
   `RRBSM_ASSERT_SAME(a_rsp_no_overflow, clock, reset, res_push, !res_full || (rsp_pop && !rsp_empty))
   `RRBSM_ASSERT_SAME(a_rom_byte_zero, clock, reset, !rsp_empty && rsp_data.rom_fetch, rsp_data.read_byte == 8'd0)
   `RRBSM_ASSERT_NEXT(a_clear_done_stays, clock, reset, !back_status.clr_busy, !back_status.clr_busy)

endmodule

// File: hw/rtl/rrbsm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rrbsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/rrbsm_fifo.sv
// Small first-in first-out queue built from registers.
module rrbsm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         pop_data,
   output logic                     full,
   output logic                     empty,
   output logic [$clog2(DEPTH):0]   count
);

   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign full     = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

// File: hw/rtl/rrbsm_front.sv
// Front end: holds the control registers, decodes each access into a command.
module rrbsm_front
   import rrbsm_pkg::*;
#(
   parameter int RAM_BANKS = RAM_BANKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  req_type               req,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cmd_type               cmd
);

   logic [3:0]            rom_log2_ff;
   logic [4:0]            ram_count_ff;
   logic                  ram_en_ff;
   logic [ROM_BANK_W-1:0] rom_bank_ff;
   logic [3:0]            ram_bank_ff;
   logic                  slot_ok;
   logic [3:0]            addr_hi;

   assign addr_hi = req.bus_addr[15:12];

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_log2_ff  <= LOG2_RESET;
         ram_count_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_ROM_LOG2:  rom_log2_ff  <= csr_wdata[3:0];
            CSR_RAM_COUNT: ram_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_en_ff   <= 1'b0;
         rom_bank_ff <= ROM_BANK_RESET;
         ram_bank_ff <= '0;
      end else if (accept && req.func == FUNC_WRITE) begin
         unique case (addr_hi) inside
            4'h0, 4'h1: ram_en_ff <= (req.write_byte[3:0] == RAM_EN_KEY);
            4'h2:       rom_bank_ff[7:0] <= req.write_byte;
            4'h3:       rom_bank_ff[8] <= req.write_byte[0];
            4'h4, 4'h5: ram_bank_ff <= req.write_byte[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      slot_ok = ram_en_ff && ({1'b0, ram_bank_ff} < ram_count_ff)
                && ({1'b0, ram_bank_ff} < 5'(RAM_BANKS));
      cmd            = '0;
      cmd.op         = OP_PASS;
      cmd.ram_bank   = ram_bank_ff;
      cmd.ram_offset = req.bus_addr[12:0];
      cmd.wr_byte    = req.write_byte;
      if (req.func == FUNC_WRITE) begin
         if ((addr_hi == 4'hA || addr_hi == 4'hB) && slot_ok) begin
            cmd.op = OP_RAM_WR;
         end
      end else begin
         unique case (addr_hi) inside
            4'h0, 4'h1, 4'h2, 4'h3: begin
               cmd.rsp.rom_fetch = 1'b1;
               cmd.rsp.rom_addr  = {{ROM_BANK_W{1'b0}}, req.bus_addr[13:0]};
            end
            4'h4, 4'h5, 4'h6, 4'h7: begin
               cmd.rsp.rom_fetch = 1'b1;
               cmd.rsp.rom_addr  = {rom_bank_ff & rom_mask(rom_log2_ff), req.bus_addr[13:0]};
            end
            4'hA, 4'hB: begin
               if (slot_ok) begin
                  cmd.op = OP_RAM_RD;
               end else begin
                  cmd.rsp.read_byte = UNMAPPED_BYTE;
               end
            end
            default: cmd.rsp.read_byte = UNMAPPED_BYTE;
         endcase
      end
   end

endmodule

// File: hw/rtl/rrbsm_back.sv
// Back end: clears and accesses the banked RAM and forms the results.
module rrbsm_back
   import rrbsm_pkg::*;
#(
   parameter int RAM_BANKS   = RAM_BANKS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   input  logic                         cmd_empty,
   output logic                         cmd_pop,
   input  logic [$clog2(QUEUE_DEPTH):0] res_count,
   output logic                         res_push,
   output rsp_type                      res_data,
   output back_status_type              status
);

   localparam int DEPTH  = RAM_BANKS * RAM_BANK_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH) + 1;

   logic              clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              s1_valid_ff;
   logic              s1_rd_ff;
   rsp_type           s1_rsp_ff;
   logic              issue;
   logic [CNT_W:0]    in_flight;
   logic [RAM_IDX_W-1:0] cmd_idx;
   logic [ADDR_W-1:0] cmd_addr;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data, rd_data;

   assign cmd_idx   = {cmd.ram_bank, cmd.ram_offset};
   assign cmd_addr  = cmd_idx[ADDR_W-1:0];
   assign in_flight = {1'b0, res_count} + (CNT_W+1)'(s1_valid_ff);
   assign issue     = !cmd_empty && !clr_busy_ff && (in_flight < (CNT_W+1)'(QUEUE_DEPTH));
   assign cmd_pop   = issue;

   always_comb begin
      wr_en   = clr_busy_ff || (issue && cmd.op == OP_RAM_WR);
      wr_addr = clr_busy_ff ? clr_addr_ff : cmd_addr;
      wr_data = clr_busy_ff ? 8'd0 : cmd.wr_byte;
      rd_en   = issue && cmd.op == OP_RAM_RD;
      clr_addr_in = clr_addr_ff + 1'b1;
      clr_busy_in = !(clr_addr_ff == ADDR_W'(DEPTH - 1));
   end

   rrbsm_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cmd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (clr_busy_ff) begin
            clr_busy_ff <= clr_busy_in;
            clr_addr_ff <= clr_addr_in;
         end
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_rd_ff  <= (cmd.op == OP_RAM_RD);
         s1_rsp_ff <= cmd.rsp;
      end
   end

   always_comb begin
      res_push = s1_valid_ff;
      res_data = s1_rsp_ff;
      if (s1_rd_ff) begin
         res_data.read_byte = rd_data;
      end
   end

   assign status.clr_busy = clr_busy_ff;

endmodule

// File: bench/tb.sv
// Self-checking testbench for the cartridge ROM/RAM bank-switch mapper.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rrbsm_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RAM_BYTES      = RAM_BANKS_DEF * RAM_BANK_BYTES;

   localparam logic [15:0] ENABLE_TOP     = 16'h1FFF;
   localparam logic [15:0] BANK_LOW_TOP   = 16'h2FFF;
   localparam logic [15:0] BANK_HIGH_TOP  = 16'h3FFF;
   localparam logic [15:0] RAM_SELECT_TOP = 16'h5FFF;
   localparam logic [15:0] ROM_FIXED_TOP  = 16'h3FFF;
   localparam logic [15:0] ROM_BANKED_LO  = 16'h4000;
   localparam logic [15:0] ROM_BANKED_TOP = 16'h7FFF;
   localparam logic [15:0] RAM_WINDOW_LO  = 16'hA000;
   localparam logic [15:0] RAM_WINDOW_TOP = 16'hBFFF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   req_type               req_data = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_idx = CSR_ROM_LOG2;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [3:0]  cfg_rom_log2 = LOG2_RESET;
   logic [4:0]  cfg_ram_count = 5'd0;
   logic        ram_enabled = 1'b0;
   logic [8:0]  rom_bank = ROM_BANK_RESET;
   logic [3:0]  ram_bank = 4'd0;
   bit   [7:0]  ram_image [0:RAM_BYTES-1];

   rsp_type expected_bus_results[$];
   int      error_count = 0;
   int      quiet_cycles = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;

   rom_ram_bank_switch_mapper DUT (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_idx(csr_idx),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic req_type bus_access(input logic f, input logic [15:0] a,
                                          input logic [7:0] d);
      req_type acc;
      acc.func       = f;
      acc.bus_addr   = a;
      acc.write_byte = d;
      return acc;
   endfunction

   function automatic rsp_type predict_bus_access(input req_type acc);
      rsp_type     res;
      logic [4:0]  banks;
      logic        hit;
      logic [16:0] idx;
      logic [3:0]  lg;
      logic [9:0]  wide_mask;
      res = '0;
      banks = (cfg_ram_count > 5'd16) ? 5'd16 : cfg_ram_count;
      hit = ram_enabled && ({1'b0, ram_bank} < banks);
      idx = {ram_bank, acc.bus_addr[12:0]};
      if (acc.func == FUNC_WRITE) begin
         if (acc.bus_addr <= ENABLE_TOP) begin
            ram_enabled = (acc.write_byte[3:0] == RAM_EN_KEY);
         end else if (acc.bus_addr <= BANK_LOW_TOP) begin
            rom_bank[7:0] = acc.write_byte;
         end else if (acc.bus_addr <= BANK_HIGH_TOP) begin
            rom_bank[8] = acc.write_byte[0];
         end else if (acc.bus_addr <= RAM_SELECT_TOP) begin
            ram_bank = acc.write_byte[3:0];
         end else if (acc.bus_addr >= RAM_WINDOW_LO && acc.bus_addr <= RAM_WINDOW_TOP
                      && hit) begin
            ram_image[idx] = acc.write_byte;
         end
      end else begin
         if (acc.bus_addr <= ROM_FIXED_TOP) begin
            res.rom_fetch = 1'b1;
            res.rom_addr  = {7'd0, acc.bus_addr};
         end else if (acc.bus_addr <= ROM_BANKED_TOP) begin
            lg = (cfg_rom_log2 > 4'd9) ? 4'd9 : cfg_rom_log2;
            wide_mask = (10'd1 << lg) - 10'd1;
            res.rom_fetch = 1'b1;
            res.rom_addr  = {rom_bank & wide_mask[8:0], acc.bus_addr[13:0]};
         end else if (acc.bus_addr >= RAM_WINDOW_LO && acc.bus_addr <= RAM_WINDOW_TOP
                      && hit) begin
            res.read_byte = ram_image[idx];
         end else begin
            res.read_byte = UNMAPPED_BYTE;
         end
      end
      return res;
   endfunction

   function automatic req_type make_random_access();
      req_type acc;
      int      pick;
      pick = $urandom_range(99);
      acc.func       = FUNC_WRITE;
      acc.bus_addr   = 16'($urandom);
      acc.write_byte = 8'($urandom);
      if (pick < 10) begin
         acc.bus_addr = 16'($urandom_range(ENABLE_TOP));
         if ($urandom_range(3) != 0) acc.write_byte[3:0] = RAM_EN_KEY;
      end else if (pick < 15) begin
         acc.bus_addr = 16'($urandom_range(BANK_LOW_TOP, ENABLE_TOP + 1));
      end else if (pick < 18) begin
         acc.bus_addr = 16'($urandom_range(BANK_HIGH_TOP, BANK_LOW_TOP + 1));
      end else if (pick < 25) begin
         acc.bus_addr = 16'($urandom_range(RAM_SELECT_TOP, ROM_BANKED_LO));
      end else if (pick < 65) begin
         acc.func = (pick < 45) ? FUNC_WRITE : FUNC_READ;
         if ($urandom_range(1) != 0) begin
            acc.bus_addr = ($urandom_range(1) != 0) ? 16'hBFF0 : RAM_WINDOW_LO;
            acc.bus_addr = acc.bus_addr + 16'($urandom_range(15));
         end else begin
            acc.bus_addr = 16'($urandom_range(RAM_WINDOW_TOP, RAM_WINDOW_LO));
         end
      end else if (pick < 85) begin
         acc.func     = FUNC_READ;
         acc.bus_addr = 16'($urandom_range(ROM_BANKED_TOP));
      end else begin
         acc.func = 1'($urandom);
      end
      return acc;
   endfunction

   task automatic send_item(input req_type acc);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_data <= acc;
      do @(posedge clock); while (req_full);
      expected_bus_results.push_back(predict_bus_access(acc));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (expected_bus_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_ROM_LOG2) cfg_rom_log2 = value[3:0];
      else cfg_ram_count = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_config(input logic [3:0] lg, input logic [4:0] count);
      write_csr(CSR_ROM_LOG2, {1'b0, lg});
      write_csr(CSR_RAM_COUNT, count);
   endtask

   task automatic test_reset_defaults();
      send_item(bus_access(FUNC_READ, 16'h0000, 8'h00));
      send_item(bus_access(FUNC_READ, 16'h4000, 8'h00));
      send_item(bus_access(FUNC_READ, 16'hA000, 8'h00));
      send_item(bus_access(FUNC_WRITE, 16'h0000, 8'h0A));
      send_item(bus_access(FUNC_WRITE, 16'hA000, 8'h55));
      send_item(bus_access(FUNC_READ, 16'hA000, 8'h00));
   endtask

   task automatic test_window_decode();
      wait_for_results();
      apply_config(4'd9, 5'd4);
      send_item(bus_access(FUNC_WRITE, 16'h1FFF, 8'hFA));
      send_item(bus_access(FUNC_WRITE, 16'h2000, 8'hFF));
      send_item(bus_access(FUNC_WRITE, 16'h3FFF, 8'hFF));
      send_item(bus_access(FUNC_READ, 16'h7FFF, 8'hFF));
      send_item(bus_access(FUNC_READ, 16'h3FFF, 8'hFF));
      send_item(bus_access(FUNC_WRITE, 16'h5FFF, 8'h03));
      send_item(bus_access(FUNC_WRITE, 16'hBFFF, 8'hA5));
      send_item(bus_access(FUNC_READ, 16'hBFFF, 8'h00));
      send_item(bus_access(FUNC_WRITE, 16'h4000, 8'hFF));
      send_item(bus_access(FUNC_WRITE, 16'hA000, 8'h12));
      send_item(bus_access(FUNC_READ, 16'hA000, 8'h00));
      send_item(bus_access(FUNC_WRITE, 16'h4000, 8'h00));
      send_item(bus_access(FUNC_WRITE, 16'hA000, 8'hFF));
      send_item(bus_access(FUNC_READ, 16'hA000, 8'h00));
      send_item(bus_access(FUNC_READ, 16'h8000, 8'h00));
      send_item(bus_access(FUNC_READ, 16'hFFFF, 8'hFF));
      send_item(bus_access(FUNC_WRITE, 16'h6000, 8'hAB));
      send_item(bus_access(FUNC_WRITE, 16'h0000, 8'h0B));
      send_item(bus_access(FUNC_READ, 16'hBFFF, 8'h00));
   endtask

   task automatic test_random_traffic(input logic [3:0] lg, input logic [4:0] count,
                                      input int send_pct, input int recv_pct,
                                      input int items);
      wait_for_results();
      apply_config(lg, count);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int i = 0; i < items; i++) begin
         if (i == items / 2) wait_for_results();
         send_item(make_random_access());
      end
   endtask

   task automatic note_mismatch(input string field, input logic [22:0] want,
                                input logic [22:0] got);
      error_count++;
      if (error_count <= 10)
         $display("mismatch in %s: expected 0x%0h, got 0x%0h", field, want, got);
   endtask

   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles = 0;
         else quiet_cycles = quiet_cycles + 1;
         if (rsp_pop && !rsp_empty) begin
            if (expected_bus_results.size() == 0) begin
               error_count++;
               if (error_count <= 10) $display("result transfer with nothing expected");
            end else begin
               want = expected_bus_results.pop_front();
               if (rsp_data.read_byte !== want.read_byte)
                  note_mismatch("read_byte", 23'(want.read_byte), 23'(rsp_data.read_byte));
               if (rsp_data.rom_fetch !== want.rom_fetch)
                  note_mismatch("rom_fetch", 23'(want.rom_fetch), 23'(rsp_data.rom_fetch));
               if (rsp_data.rom_addr !== want.rom_addr)
                  note_mismatch("rom_addr", want.rom_addr, rsp_data.rom_addr);
            end
         end
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_window_decode();
      test_random_traffic(4'd1, 5'd16, 0, 0, 330);
      test_random_traffic(4'd9, 5'd16, 53, 0, 330);
      test_random_traffic(4'd0, 5'd31, 0, 53, 330);
      test_random_traffic(4'd15, 5'd17, 27, 27, 330);
      test_random_traffic(4'd4, 5'd1, 0, 0, 330);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/rrbsm_pkg.sv
hw/rtl/rrbsm_ram.sv
hw/rtl/rrbsm_fifo.sv
hw/rtl/rrbsm_front.sv
hw/rtl/rrbsm_back.sv
hw/rtl/rom_ram_bank_switch_mapper.sv
bench/tb.sv
